[rtl/mcss_pkg.sv]
// Markov chain state sampler: shared types, codes and constants.
// No dependencies; every other file in rtl/ uses it.
`default_nettype none

package mcss_pkg;

  // fixed field widths of the channels and the config port
  localparam int CMD_W        = 2;
  localparam int IDX_FIELD_W  = 4;
  localparam int PROB_FIELD_W = 16;
  localparam int CFG_W        = 5;

  // defaults for the top-level parameters
  localparam int MAX_STATES_DEF = 16;
  localparam int PROB_BITS_DEF  = 16;

  localparam logic [CFG_W-1:0] STATES_IN_USE_RST = CFG_W'(16);

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_TRANS = 2'd0,
    CMD_WR_INIT  = 2'd1,
    CMD_DRAW     = 2'd2,
    CMD_RESTART  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DELIVER
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic wr_trans;
    logic wr_init;
    logic restart;
    logic start_draw;
    logic scan;
    logic load_out;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic done;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/mcss_in_if.sv]
// Input channel of the sampler: valid/ready handshake plus command payload.
// Depends on mcss_pkg for field widths and the command type.
`default_nettype none

interface mcss_in_if;
  logic                                 valid;
  logic                                 ready;
  mcss_pkg::cmd_t                       cmd;
  logic [mcss_pkg::IDX_FIELD_W-1:0]     row_index;
  logic [mcss_pkg::IDX_FIELD_W-1:0]     col_index;
  logic [mcss_pkg::PROB_FIELD_W-1:0]    probability;
  logic [mcss_pkg::PROB_FIELD_W-1:0]    uniform;

  modport source (
    output valid, cmd, row_index, col_index, probability, uniform,
    input  ready
  );

  modport sink (
    input  valid, cmd, row_index, col_index, probability, uniform,
    output ready
  );
endinterface

`default_nettype wire

[rtl/mcss_out_if.sv]
// Result channel of the sampler: valid/ready handshake plus sampled state.
// Depends on mcss_pkg for field widths.
`default_nettype none

interface mcss_out_if;
  logic                             valid;
  logic                             ready;
  logic [mcss_pkg::IDX_FIELD_W-1:0] state_index;
  logic                             first_of_sequence;

  modport source (
    output valid, state_index, first_of_sequence,
    input  ready
  );

  modport sink (
    input  valid, state_index, first_of_sequence,
    output ready
  );
endinterface

`default_nettype wire

[rtl/mcss_ctrl.sv]
// Sampler controller: handshake and sequencing of writes, restarts and draws.
// Depends on mcss_pkg (state enum, command codes, command/status structs).
`default_nettype none

module mcss_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire mcss_pkg::cmd_t       in_cmd,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output mcss_pkg::dp_cmd_t         dp_cmd,
  input  wire mcss_pkg::dp_status_t dp_status
);

  mcss_pkg::ctrl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;
  logic out_free;

  assign in_ready  = (state_r == mcss_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mcss_pkg::ST_IDLE: begin
        if (accept && in_cmd == mcss_pkg::CMD_DRAW) state_nxt = mcss_pkg::ST_SCAN;
      end
      mcss_pkg::ST_SCAN: begin
        if (dp_status.done) state_nxt = mcss_pkg::ST_DELIVER;
      end
      mcss_pkg::ST_DELIVER: begin
        if (out_free) state_nxt = mcss_pkg::ST_IDLE;
      end
      default: state_nxt = mcss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    dp_cmd            = '0;
    dp_cmd.wr_trans   = accept && in_cmd == mcss_pkg::CMD_WR_TRANS;
    dp_cmd.wr_init    = accept && in_cmd == mcss_pkg::CMD_WR_INIT;
    dp_cmd.restart    = accept && in_cmd == mcss_pkg::CMD_RESTART;
    dp_cmd.start_draw = accept && in_cmd == mcss_pkg::CMD_DRAW;
    dp_cmd.scan       = (state_r == mcss_pkg::ST_SCAN);
    dp_cmd.load_out   = (state_r == mcss_pkg::ST_DELIVER) && out_free;
  end

  // result register stays full until the sink takes it
  always_comb begin
    priority if (dp_cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready)           out_valid_nxt = 1'b0;
    else                          out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mcss_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/mcss_dp.sv]
// Sampler datapath: probability memories, running-sum scan, chain state,
// states_in_use register and result payload. Depends on mcss_pkg.
`default_nettype none

module mcss_dp #(
  parameter int MAX_STATES = mcss_pkg::MAX_STATES_DEF,
  parameter int PROB_BITS  = mcss_pkg::PROB_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire mcss_pkg::dp_cmd_t                   dp_cmd,
  output mcss_pkg::dp_status_t                     dp_status,
  input  wire logic [mcss_pkg::IDX_FIELD_W-1:0]    in_row_index,
  input  wire logic [mcss_pkg::IDX_FIELD_W-1:0]    in_col_index,
  input  wire logic [mcss_pkg::PROB_FIELD_W-1:0]   in_probability,
  input  wire logic [mcss_pkg::PROB_FIELD_W-1:0]   in_uniform,
  input  wire logic                                cfg_we,
  input  wire logic [mcss_pkg::CFG_W-1:0]          cfg_wdata,
  output logic [mcss_pkg::IDX_FIELD_W-1:0]         out_state_index,
  output logic                                     out_first_of_sequence
);

  localparam int IDX_W = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int CNT_W = $clog2(MAX_STATES + 1);
  localparam int AW    = 2 * IDX_W;
  localparam int ACC_W = PROB_BITS + IDX_W + 1;
  localparam int IW    = mcss_pkg::IDX_FIELD_W;

  // probability stores, no reset
  logic [PROB_BITS-1:0] trans_mem [2**AW];
  logic [PROB_BITS-1:0] init_mem  [2**IDX_W];
  logic [PROB_BITS-1:0] trans_rdata_r;
  logic [PROB_BITS-1:0] init_rdata_r;

  logic [mcss_pkg::CFG_W-1:0] states_in_use_r;
  logic [IDX_W-1:0]           cur_r;
  logic                       started_r;
  logic                       first_r;
  logic [PROB_BITS-1:0]       u_r;
  logic [CNT_W-1:0]           last_r;
  logic [CNT_W-1:0]           rd_idx_r;
  logic [CNT_W-1:0]           proc_idx_r;
  logic                       pend_r;
  logic [ACC_W-1:0]           acc_r;
  logic [IW-1:0]              out_state_r;
  logic                       out_first_r;

  logic [CNT_W-1:0]     used_n;
  logic [ACC_W-1:0]     sum;
  logic [PROB_BITS-1:0] rdata;
  logic                 hit;
  logic                 done;
  logic                 row_ok;
  logic                 col_ok;
  logic [IDX_W-1:0]     wr_row;
  logic [IDX_W-1:0]     wr_col;

  assign row_ok = 32'(in_row_index) < MAX_STATES;
  assign col_ok = 32'(in_col_index) < MAX_STATES;
  assign wr_row = IDX_W'(in_row_index);
  assign wr_col = IDX_W'(in_col_index);

  // count in use clamped to 1..MAX_STATES
  always_comb begin
    priority if (states_in_use_r == '0)           used_n = CNT_W'(1);
    else if (32'(states_in_use_r) > MAX_STATES)   used_n = CNT_W'(MAX_STATES);
    else                                          used_n = CNT_W'(states_in_use_r);
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.wr_trans && row_ok && col_ok) trans_mem[{wr_row, wr_col}] <= PROB_BITS'(in_probability);
    if (dp_cmd.wr_init && col_ok)            init_mem[wr_col] <= PROB_BITS'(in_probability);
    trans_rdata_r <= trans_mem[{cur_r, rd_idx_r[IDX_W-1:0]}];
    init_rdata_r  <= init_mem[rd_idx_r[IDX_W-1:0]];
  end

  // one entry per cycle: data for proc_idx_r arrives while rd_idx_r is read
  assign rdata = first_r ? init_rdata_r : trans_rdata_r;
  assign sum   = acc_r + ACC_W'(rdata);
  assign hit   = sum > ACC_W'(u_r);
  // no hit by the last state in use picks that last state
  assign done  = dp_cmd.scan && pend_r && (hit || proc_idx_r == last_r);

  assign dp_status.done = done;

  always_ff @(posedge clk) begin
    if (dp_cmd.start_draw) begin
      first_r <= !started_r;
      u_r     <= PROB_BITS'(in_uniform);
      last_r  <= used_n - CNT_W'(1);
      acc_r   <= '0;
    end else if (dp_cmd.scan && pend_r) begin
      acc_r <= sum;
    end
    if (dp_cmd.start_draw) begin
      rd_idx_r <= '0;
    end else if (dp_cmd.scan) begin
      rd_idx_r   <= rd_idx_r + CNT_W'(1);
      proc_idx_r <= rd_idx_r;
    end
    if (dp_cmd.load_out) begin
      out_state_r <= IW'(cur_r);
      out_first_r <= first_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      states_in_use_r <= mcss_pkg::STATES_IN_USE_RST;
      cur_r           <= '0;
      started_r       <= 1'b0;
      pend_r          <= 1'b0;
    end else begin
      if (cfg_we) states_in_use_r <= cfg_wdata;
      priority if (dp_cmd.start_draw) pend_r <= 1'b0;
      else if (dp_cmd.scan)           pend_r <= 1'b1;
      else                            pend_r <= pend_r;
      if (done) begin
        cur_r     <= proc_idx_r[IDX_W-1:0];
        started_r <= 1'b1;
      end else if (dp_cmd.restart) begin
        started_r <= 1'b0;
      end
    end
  end

  assign out_state_index       = out_state_r;
  assign out_first_of_sequence = out_first_r;

endmodule

`default_nettype wire

[rtl/markov_chain_state_sampler_unit.sv]
// Top level of the Markov chain state sampler: controller plus datapath.
// Depends on mcss_pkg, mcss_in_if, mcss_out_if, mcss_ctrl and mcss_dp.
`default_nettype none

// Draws states of a first-order Markov chain by inverse-CDF search. On a draw
// the scan walks one probability entry per cycle through the single registered
// read port of the table memory, up to the index of the state picked (at most
// states_in_use-1); the pick then moves into the output register, where the
// result is offered. New items are accepted while a result waits to be taken;
// a second draw finishes its scan and then waits for the output register to
// free up. Entries that were never written read back as whatever the memory
// holds.
module markov_chain_state_sampler_unit #(
  parameter int MAX_STATES = mcss_pkg::MAX_STATES_DEF,
  parameter int PROB_BITS  = mcss_pkg::PROB_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  mcss_in_if.sink                         in_ch,
  mcss_out_if.source                      out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [mcss_pkg::CFG_W-1:0] cfg_wdata
);

  mcss_pkg::dp_cmd_t    dp_cmd;
  mcss_pkg::dp_status_t dp_status;

  mcss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_cmd    (in_ch.cmd),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .dp_cmd    (dp_cmd),
    .dp_status (dp_status)
  );

  mcss_dp #(
    .MAX_STATES (MAX_STATES),
    .PROB_BITS  (PROB_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .dp_cmd                (dp_cmd),
    .dp_status             (dp_status),
    .in_row_index          (in_ch.row_index),
    .in_col_index          (in_ch.col_index),
    .in_probability        (in_ch.probability),
    .in_uniform            (in_ch.uniform),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .out_state_index       (out_ch.state_index),
    .out_first_of_sequence (out_ch.first_of_sequence)
  );

endmodule

`default_nettype wire

[tb/sv/sampler_check.sv]
// Scoreboard for the Markov chain state sampler: keeps its own copy of the
// tables and chain state, predicts each draw and checks the result channel.
// Depends on mcss_pkg, mcss_in_if and mcss_out_if.
module sampler_check (
  input  logic                       clk,
  input  logic                       rst_n,
  mcss_in_if                         in_mon,
  mcss_out_if                        out_mon,
  input  logic                       cfg_we,
  input  logic [mcss_pkg::CFG_W-1:0] cfg_wdata,
  output int unsigned                mismatches,
  output int unsigned                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import mcss_pkg::*;

  localparam int N_ST = MAX_STATES_DEF;

  typedef struct packed {
    logic [IDX_FIELD_W-1:0] state_index;
    logic                   first_of_sequence;
  } sample_t;

  logic [PROB_FIELD_W-1:0] trans_probs [N_ST*N_ST];
  logic [PROB_FIELD_W-1:0] init_probs  [N_ST];
  logic [IDX_FIELD_W-1:0]  chain_state;
  logic                    chain_running;
  logic [CFG_W-1:0]        scan_setting;
  sample_t                 pending_samples [$];

  function automatic int unsigned scan_length();
    int unsigned n;
    n = scan_setting;
    if (n < 1) n = 1;
    if (n > N_ST) n = N_ST;
    return n;
  endfunction

  // inverse-CDF search: first state whose running sum exceeds the fraction,
  // else the last state in use
  function automatic logic [IDX_FIELD_W-1:0] next_state(
      input logic from_init, input logic [IDX_FIELD_W-1:0] from,
      input logic [PROB_FIELD_W-1:0] frac);
    int unsigned n;
    int          k;
    logic [31:0] cdf;
    n = scan_length();
    cdf = '0;
    for (k = 0; k < n; k++) begin
      cdf += from_init ? init_probs[k] : trans_probs[int'(from)*N_ST + k];
      if (cdf > frac) return IDX_FIELD_W'(k);
    end
    return IDX_FIELD_W'(n - 1);
  endfunction

  always @(posedge clk) begin
    sample_t want;
    if (!rst_n) begin
      chain_state   = '0;
      chain_running = 1'b0;
      scan_setting  = STATES_IN_USE_RST;
      pending_samples.delete();
      mismatches    = 0;
      outstanding   = 0;
    end else begin
      if (cfg_we) scan_setting = cfg_wdata;

      if (out_mon.valid && out_mon.ready) begin
        if (pending_samples.size() == 0) begin
          $error("unexpected result transfer: state_index %0d first_of_sequence %0d",
                 out_mon.state_index, out_mon.first_of_sequence);
          mismatches++;
        end else begin
          want = pending_samples.pop_front();
          if (out_mon.state_index !== want.state_index) begin
            $error("state_index: expected %0d, got %0d",
                   want.state_index, out_mon.state_index);
            mismatches++;
          end
          if (out_mon.first_of_sequence !== want.first_of_sequence) begin
            $error("first_of_sequence: expected %0d, got %0d",
                   want.first_of_sequence, out_mon.first_of_sequence);
            mismatches++;
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.cmd)
          CMD_WR_TRANS:
            trans_probs[int'(in_mon.row_index)*N_ST + int'(in_mon.col_index)] =
              in_mon.probability;
          CMD_WR_INIT: init_probs[in_mon.col_index] = in_mon.probability;
          CMD_RESTART: chain_running = 1'b0;
          default: begin
            // draw: initial vector when no sequence runs, else row of last pick
            want.first_of_sequence = !chain_running;
            want.state_index = next_state(!chain_running, chain_state, in_mon.uniform);
            chain_state   = want.state_index;
            chain_running = 1'b1;
            pending_samples.push_back(want);
          end
        endcase
      end

      outstanding = pending_samples.size();
    end
  end

endmodule

[tb/sv/testbench.sv]
// Top of the sampler testbench: clock, reset, stimulus and back-pressure.
// Depends on mcss_pkg, the channel interfaces, sampler_check and the RTL top.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mcss_pkg::*;

  localparam int          N_ST         = MAX_STATES_DEF;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int          DRAIN_CYCLES = 24;  // worst-case draw latency plus margin

  typedef struct {
    cmd_t                    cmd;
    logic [IDX_FIELD_W-1:0]  row_index;
    logic [IDX_FIELD_W-1:0]  col_index;
    logic [PROB_FIELD_W-1:0] probability;
    logic [PROB_FIELD_W-1:0] uniform;
  } sampler_cmd_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int unsigned      mismatches;
  int unsigned      outstanding;
  int unsigned      cycle_count = 0;
  bit               hold_results = 1'b0;
  bit               steady_flow = 1'b0;
  int unsigned      prob_span = 8192;  // upper bound of well-formed entries
  int unsigned      gap_pct = 0;

  mcss_in_if  in_ch ();
  mcss_out_if out_ch ();

  markov_chain_state_sampler_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  sampler_check sample_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_results) begin
        out_ch.ready <= 1'b0;
        repeat (160) @(negedge clk);
        hold_results = 1'b0;
      end else if (steady_flow) begin
        out_ch.ready <= 1'b1;
        @(negedge clk);
      end else if ($urandom_range(0, 99) < 30) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  // called at a falling edge; returns at a falling edge with valid possibly still high
  task automatic push(input sampler_cmd_t it);
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= it.cmd;
    in_ch.row_index   <= it.row_index;
    in_ch.col_index   <= it.col_index;
    in_ch.probability <= it.probability;
    in_ch.uniform     <= it.uniform;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (!steady_flow && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic send(input cmd_t c, input logic [IDX_FIELD_W-1:0] r,
                      input logic [IDX_FIELD_W-1:0] col,
                      input logic [PROB_FIELD_W-1:0] p,
                      input logic [PROB_FIELD_W-1:0] u);
    sampler_cmd_t it;
    it.cmd         = c;
    it.row_index   = r;
    it.col_index   = col;
    it.probability = p;
    it.uniform     = u;
    push(it);
  endtask

  function automatic logic [PROB_FIELD_W-1:0] spread_prob();
    return PROB_FIELD_W'($urandom_range(0, prob_span));
  endfunction

  function automatic logic [PROB_FIELD_W-1:0] any_prob();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return PROB_FIELD_W'($urandom);
      default: return spread_prob();
    endcase
  endfunction

  function automatic logic [PROB_FIELD_W-1:0] any_uniform();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return PROB_FIELD_W'($urandom);
    endcase
  endfunction

  task automatic write_row(input logic [IDX_FIELD_W-1:0] r);
    int c;
    for (c = 0; c < N_ST; c++)
      send(CMD_WR_TRANS, r, IDX_FIELD_W'(c), spread_prob(), PROB_FIELD_W'($urandom));
  endtask

  task automatic write_init_vector();
    int c;
    for (c = 0; c < N_ST; c++)
      send(CMD_WR_INIT, IDX_FIELD_W'($urandom), IDX_FIELD_W'(c), spread_prob(),
           PROB_FIELD_W'($urandom));
  endtask

  // mostly draws against well-formed rows, with stray writes and restarts
  task automatic random_items(input int count);
    sampler_cmd_t it;
    int           r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        write_row(IDX_FIELD_W'($urandom));
      end else if (r < 6) begin
        write_init_vector();
      end else begin
        it.row_index   = IDX_FIELD_W'($urandom);
        it.col_index   = IDX_FIELD_W'($urandom);
        it.probability = any_prob();
        it.uniform     = any_uniform();
        if (r < 58)      it.cmd = CMD_DRAW;
        else if (r < 66) it.cmd = CMD_RESTART;
        else if (r < 78) it.cmd = CMD_WR_INIT;
        else             it.cmd = CMD_WR_TRANS;
        push(it);
      end
    end
  endtask

  // drop valid, wait for every outstanding result, then let in-flight writes land
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_states(input logic [CFG_W-1:0] v);
    int unsigned eff;
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    eff = (v == 0) ? 1 : ((v > N_ST) ? N_ST : v);
    prob_span = 131072 / eff;
    if (prob_span > 65535) prob_span = 65535;
    case ($urandom_range(0, 2))
      0:       gap_pct = 0;
      1:       gap_pct = 15;
      default: gap_pct = 35;
    endcase
  endtask

  initial begin
    int r;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_WR_TRANS;
    in_ch.row_index   = '0;
    in_ch.col_index   = '0;
    in_ch.probability = '0;
    in_ch.uniform     = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fill both stores so no draw ever reads an unwritten entry
    gap_pct = 10;
    write_init_vector();
    for (r = 0; r < N_ST; r++) write_row(IDX_FIELD_W'(r));

    // draws at uniform extremes, first draw after reset, double restart
    send(CMD_DRAW,     4'h0, 4'h0, 16'h0000, 16'h0000);
    send(CMD_DRAW,     4'hF, 4'hF, 16'hFFFF, 16'hFFFF);
    send(CMD_DRAW,     4'h5, 4'hA, 16'h5555, 16'hFFFF);
    send(CMD_RESTART,  4'hF, 4'hF, 16'hFFFF, 16'hFFFF);
    send(CMD_RESTART,  4'h0, 4'h0, 16'h0000, 16'h0000);
    send(CMD_WR_INIT,  4'h0, 4'hF, 16'hFFFF, 16'h0000);
    send(CMD_WR_INIT,  4'hF, 4'h0, 16'h0000, 16'hFFFF);
    send(CMD_DRAW,     4'h0, 4'h0, 16'h0000, 16'h8000);
    send(CMD_WR_TRANS, 4'hF, 4'hF, 16'hFFFF, 16'h0000);
    send(CMD_WR_TRANS, 4'h0, 4'h0, 16'h0000, 16'hFFFF);
    send(CMD_DRAW,     4'hA, 4'h5, 16'hAAAA, 16'h1234);
    send(CMD_DRAW,     4'h0, 4'h0, 16'h0000, 16'h0000);
    send(CMD_DRAW,     4'h0, 4'h0, 16'h0000, 16'hFFFE);

    // full scan; result side held off while draws keep coming
    set_states(5'd16);
    hold_results = 1'b1;
    repeat (40)
      send(CMD_DRAW, IDX_FIELD_W'($urandom), IDX_FIELD_W'($urandom),
           PROB_FIELD_W'($urandom), any_uniform());
    random_items(45);

    // single state: a full-scale entry never exceeds the top uniform
    set_states(5'd1);
    send(CMD_WR_INIT, 4'h3, 4'h0, 16'hFFFF, 16'h0000);
    send(CMD_RESTART, 4'h0, 4'h0, 16'h0000, 16'h0000);
    send(CMD_DRAW,    4'h0, 4'h0, 16'h0000, 16'hFFFF);
    send(CMD_DRAW,    4'h0, 4'h0, 16'h0000, 16'hFFFE);
    random_items(40);

    // zero count acts as one, oversize count acts as full
    set_states(5'd0);
    random_items(35);
    set_states(5'd31);
    random_items(45);

    // two states, all-zero initial entries: nothing qualifies, last state wins
    set_states(5'd2);
    send(CMD_WR_INIT, 4'h0, 4'h0, 16'h0000, 16'h0000);
    send(CMD_WR_INIT, 4'h0, 4'h1, 16'h0000, 16'h0000);
    send(CMD_RESTART, 4'h0, 4'h0, 16'h0000, 16'h0000);
    send(CMD_DRAW,    4'h0, 4'h0, 16'h0000, 16'h0000);
    send(CMD_DRAW,    4'h0, 4'h0, 16'h0000, 16'hFFFF);
    random_items(45);

    set_states(5'd8);
    random_items(55);
    set_states(5'd17);
    random_items(45);
    set_states(CFG_W'($urandom_range(3, 15)));
    random_items(55);
    set_states(CFG_W'($urandom_range(0, 31)));
    random_items(50);

    // closing stretch at full rate on both sides
    set_states(5'd16);
    steady_flow = 1'b1;
    random_items(65);

    settle();
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
